@@ src/scc_pkg.sv @@
`default_nettype none
package scc_pkg;

    localparam int CoordW = 32;
    localparam int RadW   = 31;
    localparam int BncW   = 17;
    localparam int CntW   = 8;
    localparam int IdW    = 16;
    localparam int InDataW  = 80;
    localparam int OutDataW = 104;
    localparam int OutUserW = 2;
    localparam int AddrW    = 5;

    // Register index codes (byte address / 4)
    typedef enum logic [2:0] {
        REG_SEG_START_X = 3'd0,
        REG_SEG_START_Y = 3'd1,
        REG_SEG_END_X   = 3'd2,
        REG_SEG_END_Y   = 3'd3,
        REG_RADIUS      = 3'd4,
        REG_BOUNCE      = 3'd5,
        REG_LIMIT       = 3'd6,
        REG_UNUSED      = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [CoordW-1:0] ax;
        logic signed [CoordW-1:0] ay;
        logic signed [CoordW-1:0] bx;
        logic signed [CoordW-1:0] by;
        logic [RadW-1:0]          radius;
        logic [BncW-1:0]          bounce;
        logic [CntW-1:0]          limit;
    } t_cfg;

    // Queued item: offsets from both segment ends, already saturated
    typedef struct packed {
        logic signed [CoordW-1:0] dx;
        logic signed [CoordW-1:0] dy;
        logic signed [CoordW-1:0] ex;
        logic signed [CoordW-1:0] ey;
        logic [IdW-1:0]           id;
        logic                     last;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROD,
        S_CLASS,
        S_DIV,
        S_NEAR,
        S_DSQ,
        S_SQRT,
        S_NSET,
        S_NORM,
        S_DONE
    } t_state;

    // Clamp to +/- (2^31 - 1)
    function automatic logic signed [CoordW-1:0] sat34(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -34'sd2147483647) begin
            return 32'sh80000001;
        end else begin
            return v[CoordW-1:0];
        end
    endfunction

    function automatic logic signed [CoordW-1:0] sat_sub(
        input logic signed [CoordW-1:0] a,
        input logic signed [CoordW-1:0] b
    );
        return sat34(34'(a) - 34'(b));
    endfunction

    // Magnitude of a saturated value, never above 2^31 - 1
    function automatic logic [CoordW-1:0] mag(input logic signed [CoordW-1:0] v);
        return v[CoordW-1] ? CoordW'(-v) : CoordW'(v);
    endfunction

endpackage
`default_nettype wire

@@ src/segment_circle_contact.sv @@
`default_nettype none
// Circle against line segment contact test. The segment ends, circle radius,
// restitution and per-batch contact limit are set over the APB port; the
// user must set them only while no circle is in flight, which the block does
// not enforce. Each stream transaction carries one circle centre and yields
// exactly one result transaction, in order. A two-entry queue sits between
// the input side and the arithmetic engine, and a result register sits at the
// output, so input and output stall independently. The engine handles one
// circle at a time on a single shared 33x33 multiplier: a circle projecting
// into the segment interior and touching runs a projection divide, a square
// root and a normal divide, a touch at a segment end skips the projection
// divide, a miss at an end stops after the distance check, and a circle seen
// after the contact limit was reached skips the arithmetic. The contact count clears after the tlast transaction.
module segment_circle_contact (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // APB configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [scc_pkg::AddrW-1:0]     paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    // Input stream
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [scc_pkg::InDataW-1:0]   i_s_tdata,  // centre_x, centre_y, body_id
    input  wire logic                          i_s_tlast,  // batch_end
    // Result stream
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // normal_x, normal_y, depth, restitution_out, body_echo, contacts_so_far
    output logic [scc_pkg::OutDataW-1:0]       o_m_tdata,
    output logic [scc_pkg::OutUserW-1:0]       o_m_tuser   // hit, limit_reached
);
    import scc_pkg::*;

    t_cfg       w_cfg;
    t_queue_out w_q;
    logic       w_pop;

    scc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    scc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_pop      (w_pop),
        .o_q        (w_q)
    );

    scc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_q        (w_q),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // A contact is never reported together with the limit flag
    a_hit_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("hit and limit_reached both set");

    // Limit reached: no normal, depth or restitution
    a_lim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (o_m_tdata[79:0] == '0))
        else $error("contact fields set on limited result");

    // A recorded contact always counts at least one
    a_hit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[103:96] != '0))
        else $error("contact with zero count");

    // Without a contact there is no depth
    a_miss_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[62:32] == '0))
        else $error("depth on a miss");

endmodule
`default_nettype wire

@@ src/scc_regs.sv @@
`default_nettype none
module scc_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [scc_pkg::AddrW-1:0]   paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output scc_pkg::t_cfg                    o_cfg
);
    import scc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;

    assign w_idx  = t_reg_idx'(paddr[AddrW-1:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ax     <= '0;
            r_cfg.ay     <= '0;
            r_cfg.bx     <= 32'sd65536;
            r_cfg.by     <= '0;
            r_cfg.radius <= 31'd65536;
            r_cfg.bounce <= 17'd65536;
            r_cfg.limit  <= 8'd255;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_SEG_START_X: r_cfg.ax     <= pwdata;
                REG_SEG_START_Y: r_cfg.ay     <= pwdata;
                REG_SEG_END_X:   r_cfg.bx     <= pwdata;
                REG_SEG_END_Y:   r_cfg.by     <= pwdata;
                REG_RADIUS:      r_cfg.radius <= pwdata[RadW-1:0];
                REG_BOUNCE:      r_cfg.bounce <= pwdata[BncW-1:0];
                REG_LIMIT:       r_cfg.limit  <= pwdata[CntW-1:0];
                REG_UNUSED:      ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (w_idx)
            REG_SEG_START_X: prdata = r_cfg.ax;
            REG_SEG_START_Y: prdata = r_cfg.ay;
            REG_SEG_END_X:   prdata = r_cfg.bx;
            REG_SEG_END_Y:   prdata = r_cfg.by;
            REG_RADIUS:      prdata = 32'(r_cfg.radius);
            REG_BOUNCE:      prdata = 32'(r_cfg.bounce);
            REG_LIMIT:       prdata = 32'(r_cfg.limit);
            REG_UNUSED:      prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ src/scc_front.sv @@
`default_nettype none
module scc_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  scc_pkg::t_cfg                      i_cfg,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [scc_pkg::InDataW-1:0]   i_s_tdata,
    input  wire logic                          i_s_tlast,
    input  wire logic                          i_pop,
    output scc_pkg::t_queue_out                o_q
);
    import scc_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      w_new;
    logic       w_push;
    logic       w_pop;
    logic signed [CoordW-1:0] w_cx;
    logic signed [CoordW-1:0] w_cy;

    assign w_cx = i_s_tdata[31:0];
    assign w_cy = i_s_tdata[63:32];

    // Offsets from both segment ends
    always_comb begin
        w_new.dx   = sat_sub(w_cx, i_cfg.ax);
        w_new.dy   = sat_sub(w_cy, i_cfg.ay);
        w_new.ex   = sat_sub(w_cx, i_cfg.bx);
        w_new.ey   = sat_sub(w_cy, i_cfg.by);
        w_new.id   = i_s_tdata[79:64];
        w_new.last = i_s_tlast;
    end

    assign o_s_tready = (r_cnt != 2'd2);
    assign w_push     = i_s_tvalid && o_s_tready;
    assign w_pop      = i_pop && (r_cnt != 2'd0);
    assign o_q.valid  = (r_cnt != 2'd0);
    assign o_q.item   = r_mem[r_rp];

    // Two-entry queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_new;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule
`default_nettype wire

@@ src/scc_back.sv @@
`default_nettype none
module scc_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  scc_pkg::t_cfg                       i_cfg,
    input  scc_pkg::t_queue_out                 i_q,
    output logic                                o_pop,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [scc_pkg::OutDataW-1:0]        o_m_tdata,
    output logic [scc_pkg::OutUserW-1:0]        o_m_tuser
);
    import scc_pkg::*;

    t_state r_state, n_state;
    logic [4:0] r_step;

    t_item r_it;
    logic signed [CoordW-1:0] r_lx, r_ly, r_vx, r_vy;
    logic signed [64:0] r_proj;
    logic [63:0] r_sqlen, r_rem, r_dsq, r_x, r_res;
    logic [31:0] r_t, r_m, r_remx, r_remy;
    logic [15:0] r_nlx, r_nly, r_qx, r_qy;
    logic        r_hit, r_lim;
    logic [CntW-1:0] r_count;

    logic        r_ovalid;
    logic [OutDataW-1:0] r_odata;
    logic [OutUserW-1:0] r_ouser;

    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_mp;
    logic [63:0] w_mpu;
    logic        w_out_free, w_inside, w_load;
    logic [64:0] w_rem2;
    logic [63:0] w_bit, w_sum, w_round;
    logic [31:0] w_px;
    logic signed [33:0] w_pd;
    logic [CoordW-1:0] w_avx, w_avy;
    logic [45:0] w_numx, w_numy;
    logic [32:0] w_rx2, w_ry2;
    logic [15:0] w_cqx, w_cqy;
    logic [CntW-1:0] w_cnt_next;

    // Shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_PROD: begin
                unique case (r_step[1:0])
                    2'd0: begin w_ma = 33'(r_it.dx); w_mb = 33'(r_lx); end
                    2'd1: begin w_ma = 33'(r_it.dy); w_mb = 33'(r_ly); end
                    2'd2: begin w_ma = 33'(r_lx);    w_mb = 33'(r_lx); end
                    2'd3: begin w_ma = 33'(r_ly);    w_mb = 33'(r_ly); end
                endcase
            end
            S_NEAR: begin
                w_ma = $signed({1'b0, r_step[0] ? mag(r_ly) : mag(r_lx)});
                w_mb = $signed({1'b0, r_t});
            end
            S_DSQ: begin
                unique case (r_step[1:0])
                    2'd0:    begin w_ma = 33'(r_vx); w_mb = 33'(r_vx); end
                    2'd1:    begin w_ma = 33'(r_vy); w_mb = 33'(r_vy); end
                    default: begin
                        w_ma = $signed({2'b0, i_cfg.radius});
                        w_mb = $signed({2'b0, i_cfg.radius});
                    end
                endcase
            end
            default: ;
        endcase
    end
    assign w_mp  = 66'(w_ma) * 66'(w_mb);
    assign w_mpu = w_mp[63:0];

    // Datapath helpers
    assign w_inside = (r_dsq < w_mpu);
    assign w_rem2   = {r_rem, 1'b0};
    assign w_bit    = 64'd1 << {5'd31 - r_step, 1'b0};
    assign w_sum    = r_res + w_bit;
    assign w_round  = w_mpu + 64'h8000_0000;
    assign w_px     = w_round[63:32];
    always_comb begin
        if (r_step[0]) begin
            w_pd = 34'(r_it.dy) - (r_ly[CoordW-1] ? -34'(w_px) : 34'(w_px));
        end else begin
            w_pd = 34'(r_it.dx) - (r_lx[CoordW-1] ? -34'(w_px) : 34'(w_px));
        end
    end
    assign w_avx  = mag(r_vx);
    assign w_avy  = mag(r_vy);
    assign w_numx = {w_avx[30:0], 14'b0} + 46'(r_res[31:1]);
    assign w_numy = {w_avy[30:0], 14'b0} + 46'(r_res[31:1]);
    assign w_rx2  = {r_remx, r_nlx[15]};
    assign w_ry2  = {r_remy, r_nly[15]};
    assign w_cqx  = (r_qx > 16'd16384) ? 16'd16384 : r_qx;
    assign w_cqy  = (r_qy > 16'd16384) ? 16'd16384 : r_qy;
    assign w_cnt_next = r_count + CntW'(r_hit);
    assign w_out_free = !r_ovalid || i_m_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_q.valid) n_state = (r_count >= i_cfg.limit) ? S_DONE : S_PROD;
            S_PROD:  if (r_step == 5'd3) n_state = S_CLASS;
            S_CLASS: begin
                if (r_proj[64] || r_proj == '0 || r_proj[63:0] >= r_sqlen) begin
                    n_state = S_DSQ;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV:   if (r_step == 5'd31) n_state = S_NEAR;
            S_NEAR:  if (r_step == 5'd1) n_state = S_DSQ;
            S_DSQ:   if (r_step == 5'd2) n_state = w_inside ? S_SQRT : S_DONE;
            S_SQRT:  if (r_step == 5'd31) n_state = S_NSET;
            S_NSET:  n_state = (r_res == '0) ? S_DONE : S_NORM;
            S_NORM:  if (r_step == 5'd15) n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop  = (r_state == S_IDLE) && i_q.valid;
        w_load = (r_state == S_DONE) && w_out_free;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= (n_state != r_state) ? 5'd0 : r_step + 5'd1;
            if (w_load) begin
                r_count <= r_it.last ? '0 : w_cnt_next;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Item datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_it    <= i_q.item;
                r_lx    <= sat_sub(i_cfg.bx, i_cfg.ax);
                r_ly    <= sat_sub(i_cfg.by, i_cfg.ay);
                r_proj  <= '0;
                r_sqlen <= '0;
                r_lim   <= (r_count >= i_cfg.limit);
                r_hit   <= 1'b0;
                r_res   <= '0;
                r_qx    <= '0;
                r_qy    <= '0;
            end
            S_PROD: begin
                if (r_step[1]) r_sqlen <= r_sqlen + w_mpu;
                else           r_proj  <= r_proj + w_mp[64:0];
            end
            S_CLASS: begin
                if (r_proj[64] || r_proj == '0) begin
                    r_vx <= r_it.dx;
                    r_vy <= r_it.dy;
                end else if (r_proj[63:0] >= r_sqlen) begin
                    r_vx <= r_it.ex;
                    r_vy <= r_it.ey;
                end
                r_rem <= r_proj[63:0];
                r_t   <= '0;
            end
            S_DIV: begin
                if (w_rem2 >= {1'b0, r_sqlen}) begin
                    r_rem <= 64'(w_rem2 - {1'b0, r_sqlen});
                    r_t   <= {r_t[30:0], 1'b1};
                end else begin
                    r_rem <= w_rem2[63:0];
                    r_t   <= {r_t[30:0], 1'b0};
                end
            end
            S_NEAR: begin
                if (r_step[0]) r_vy <= sat34(w_pd);
                else           r_vx <= sat34(w_pd);
            end
            S_DSQ: begin
                unique case (r_step[1:0])
                    2'd0:    r_dsq <= w_mpu;
                    2'd1:    r_dsq <= r_dsq + w_mpu;
                    default: begin
                        r_hit <= w_inside;
                        r_x   <= r_dsq;
                        r_res <= '0;
                    end
                endcase
            end
            S_SQRT: begin
                if (r_x >= w_sum) begin
                    r_x   <= r_x - w_sum;
                    r_res <= (r_res >> 1) + w_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
            end
            S_NSET: begin
                r_m    <= r_res[31:0];
                r_remx <= 32'(w_numx[45:16]);
                r_remy <= 32'(w_numy[45:16]);
                r_nlx  <= w_numx[15:0];
                r_nly  <= w_numy[15:0];
            end
            S_NORM: begin
                // One quotient bit per cycle for both components
                if (w_rx2 >= {1'b0, r_m}) begin
                    r_remx <= 32'(w_rx2 - {1'b0, r_m});
                    r_qx   <= {r_qx[14:0], 1'b1};
                end else begin
                    r_remx <= w_rx2[31:0];
                    r_qx   <= {r_qx[14:0], 1'b0};
                end
                if (w_ry2 >= {1'b0, r_m}) begin
                    r_remy <= 32'(w_ry2 - {1'b0, r_m});
                    r_qy   <= {r_qy[14:0], 1'b1};
                end else begin
                    r_remy <= w_ry2[31:0];
                    r_qy   <= {r_qy[14:0], 1'b0};
                end
                r_nlx <= {r_nlx[14:0], 1'b0};
                r_nly <= {r_nly[14:0], 1'b0};
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ouser <= {r_lim, r_hit};
            r_odata <= {
                w_cnt_next,
                r_it.id,
                r_hit ? i_cfg.bounce : {BncW{1'b0}},
                r_hit ? RadW'(i_cfg.radius - r_res[RadW-1:0]) : {RadW{1'b0}},
                r_vy[CoordW-1] ? 16'(-w_cqy) : w_cqy,
                r_vx[CoordW-1] ? 16'(-w_cqx) : w_cqx
            };
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

endmodule
`default_nettype wire

@@ dv/tb_segment_circle_contact.sv @@
`timescale 1ns / 100ps

module tb_segment_circle_contact;
    import scc_pkg::*;

    localparam longint SatLim = 64'sd2147483647;
    localparam int StallLimit = 20000;
    localparam int DrainCycles = 150;

    typedef struct {
        bit              hit;
        bit              lim;
        logic [15:0]     nx;
        logic [15:0]     ny;
        logic [30:0]     depth;
        logic [16:0]     rest;
        logic [15:0]     id;
        logic [7:0]      cnt;
    } contact_t;

    // Scoreboard: segment/circle predictor plus queue of expected contacts
    class contact_scoreboard;
        logic [31:0] seg_ax, seg_ay, seg_bx, seg_by;
        logic [30:0] radius;
        logic [16:0] bounce;
        logic [7:0]  limit;
        logic [7:0]  count;
        contact_t    pending[$];
        int          errors;

        function new();
            seg_ax = 0; seg_ay = 0; seg_bx = 32'h10000; seg_by = 0;
            radius = 31'h10000; bounce = 17'h10000; limit = 8'd255; count = 0;
            errors = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] v);
            case (idx)
                REG_SEG_START_X: seg_ax = v;
                REG_SEG_START_Y: seg_ay = v;
                REG_SEG_END_X:   seg_bx = v;
                REG_SEG_END_Y:   seg_by = v;
                REG_RADIUS:      radius = v[30:0];
                REG_BOUNCE:      bounce = v[16:0];
                REG_LIMIT:       limit = v[7:0];
                default: ;
            endcase
        endfunction

        function longint clamp(longint v);
            if (v > SatLim) return SatLim;
            if (v < -SatLim) return -SatLim;
            return v;
        endfunction

        function longint unsigned absval(longint v);
            return v < 0 ? longint'(-v) : v;
        endfunction

        function longint unsigned root_floor(longint unsigned x);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        // Q1.14 unit component, rounded half up in magnitude
        function logic [15:0] unit_comp(longint v, longint unsigned m);
            longint unsigned q;
            q = (absval(v) * 16384 + (m >> 1)) / m;
            if (q > 16384) q = 16384;
            return v < 0 ? 16'(-q) : 16'(q);
        endfunction

        // Accepted circle: compute its contact and queue it
        function void note_circle(logic [31:0] cxr, logic [31:0] cyr, logic [15:0] id,
                                  bit last);
            contact_t e;
            longint cx, cy, ax, ay, bx, by, dx, dy, lx, ly, proj, vx, vy;
            longint unsigned sqlen, rem, t, px, py, dsq, r, m;
            cx = longint'($signed(cxr)); cy = longint'($signed(cyr));
            ax = longint'($signed(seg_ax)); ay = longint'($signed(seg_ay));
            bx = longint'($signed(seg_bx)); by = longint'($signed(seg_by));
            e = '{default: 0};
            e.id = id;
            if (count >= limit) begin
                e.lim = 1;
            end else begin
                dx = clamp(cx - ax); dy = clamp(cy - ay);
                lx = clamp(bx - ax); ly = clamp(by - ay);
                proj = dx * lx + dy * ly;
                sqlen = longint'(lx * lx) + longint'(ly * ly);
                if (proj <= 0) begin
                    vx = dx; vy = dy;
                end else if (unsigned'(proj) >= sqlen) begin
                    vx = clamp(cx - bx); vy = clamp(cy - by);
                end else begin
                    // Q0.32 fraction along the segment
                    rem = proj; t = 0;
                    for (int i = 0; i < 32; i++) begin
                        rem <<= 1;
                        t <<= 1;
                        if (rem >= sqlen) begin
                            rem -= sqlen;
                            t |= 1;
                        end
                    end
                    px = (absval(lx) * t + 64'h80000000) >> 32;
                    py = (absval(ly) * t + 64'h80000000) >> 32;
                    vx = clamp(dx - (lx < 0 ? -longint'(px) : longint'(px)));
                    vy = clamp(dy - (ly < 0 ? -longint'(py) : longint'(py)));
                end
                dsq = longint'(vx * vx) + longint'(vy * vy);
                r = radius;
                if (dsq < r * r) begin
                    m = root_floor(dsq);
                    e.hit = 1;
                    if (m != 0) begin
                        e.nx = unit_comp(vx, m);
                        e.ny = unit_comp(vy, m);
                    end
                    e.depth = 31'(r - m);
                    e.rest = bounce;
                    count++;
                end
            end
            e.cnt = count;
            if (last) count = 0;
            pending.push_back(e);
        endfunction

        function void report(string what, longint got, longint want, logic [15:0] id);
            $display("MISMATCH %s body %0d: got %0h expected %0h", what, id, got, want);
            errors++;
        endfunction

        function void check_contact(contact_t g);
            contact_t e;
            if (pending.size() == 0) begin
                report("unexpected result", 0, 0, g.id);
                return;
            end
            e = pending.pop_front();
            if (g.hit !== e.hit) report("hit", g.hit, e.hit, e.id);
            if (g.lim !== e.lim) report("limit_reached", g.lim, e.lim, e.id);
            if (g.nx !== e.nx) report("normal_x", g.nx, e.nx, e.id);
            if (g.ny !== e.ny) report("normal_y", g.ny, e.ny, e.id);
            if (g.depth !== e.depth) report("depth", g.depth, e.depth, e.id);
            if (g.rest !== e.rest) report("restitution", g.rest, e.rest, e.id);
            if (g.id !== e.id) report("body_echo", g.id, e.id, e.id);
            if (g.cnt !== e.cnt) report("contacts_so_far", g.cnt, e.cnt, e.id);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel, penable, pwrite;
    logic [AddrW-1:0]      paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [InDataW-1:0]    i_s_tdata;   // centre_x, centre_y, body_id
    logic                  i_s_tlast;   // batch_end
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    // normal_x, normal_y, depth, restitution_out, body_echo, contacts_so_far
    logic [OutDataW-1:0]   o_m_tdata;
    logic [OutUserW-1:0]   o_m_tuser;   // hit, limit_reached

    contact_scoreboard sb;
    bit     calm;
    int     stall_cycles;
    bit     timed_out;
    logic [15:0] next_id;

    segment_circle_contact dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tlast(i_s_tlast),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function bit idle_now();
        return !calm && $urandom_range(99) < 21;
    endfunction

    // Input transactions go to the predictor, results to the checker
    always @(posedge i_clk) begin
        contact_t g;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                sb.note_circle(i_s_tdata[31:0], i_s_tdata[63:32], i_s_tdata[79:64],
                               i_s_tlast);
            if (o_m_tvalid && i_m_tready) begin
                g.nx    = o_m_tdata[15:0];
                g.ny    = o_m_tdata[31:16];
                g.depth = o_m_tdata[62:32];
                g.rest  = o_m_tdata[79:63];
                g.id    = o_m_tdata[95:80];
                g.cnt   = o_m_tdata[103:96];
                g.hit   = o_m_tuser[0];
                g.lim   = o_m_tuser[1];
                sb.check_contact(g);
            end
            i_m_tready <= !idle_now();
        end
    end

    // Watchdog on cycles with no transaction of any kind
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit && !timed_out) begin
            timed_out <= 1;
            $display("timeout");
            $display("tb_segment_circle_contact failed");
            $finish;
        end
    end

    task automatic reg_write(t_reg_idx idx, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= AddrW'(idx) << 2; pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_reg(idx, v);
    endtask

    // Hold input until every contact is back and the engine has gone quiet
    task automatic wait_idle();
        i_s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic send_circle(logic [31:0] x, logic [31:0] y, bit last);
        if (idle_now()) begin
            i_s_tvalid <= 0;
            do @(posedge i_clk); while (idle_now());
        end
        i_s_tvalid <= 1;
        i_s_tdata <= {next_id, y, x};
        i_s_tlast <= last;
        next_id = next_id + 16'd4099;
        @(negedge i_clk);
        while (!o_s_tready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_segment(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                               logic [31:0] by, logic [31:0] r);
        reg_write(REG_SEG_START_X, ax);
        reg_write(REG_SEG_START_Y, ay);
        reg_write(REG_SEG_END_X, bx);
        reg_write(REG_SEG_END_Y, by);
        reg_write(REG_RADIUS, r);
    endtask

    function automatic logic [31:0] to_coord(longint v);
        if (v > SatLim) v = SatLim;
        if (v < -SatLim - 1) v = -SatLim - 1;
        return 32'(v);
    endfunction

    function automatic longint srand(int unsigned span);
        return longint'($urandom_range(2 * span)) - longint'(span);
    endfunction

    // One phase: random segment of a random scale, circles mostly near it
    task automatic random_phase(int n);
        int sh;
        longint ax, ay, bx, by, r, t, px, py;
        sh = $urandom_range(30, 4);
        ax = srand(1 << sh) ; ay = srand(1 << sh);
        bx = ($urandom_range(7) == 0) ? ax : srand(1 << sh);
        by = ($urandom_range(7) == 0) ? ay : srand(1 << sh);
        r = $urandom_range((1 << (sh > 30 ? 30 : sh)), 1);
        if ($urandom_range(15) == 0) r = 0;
        if ($urandom_range(15) == 0) r = 32'h7FFFFFFF;
        set_segment(to_coord(ax), to_coord(ay), to_coord(bx), to_coord(by), 32'(r));
        reg_write(REG_BOUNCE, $urandom_range(3) == 0 ? 32'h10000 : $urandom_range(65536));
        reg_write(REG_LIMIT, $urandom_range(3) == 0 ? 32'd255 : $urandom_range(12));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                send_circle($urandom, $urandom, $urandom_range(15) == 0);
            end else begin
                t = longint'($urandom_range(1400)) - 200;
                px = ax + (bx - ax) * t / 1000 + srand(32'(r < 4 ? 4 : r) * 2 > 0 ?
                     32'(r < 4 ? 4 : (r > 32'h3FFFFFFF ? 32'h3FFFFFFF : r)) : 4);
                py = ay + (by - ay) * t / 1000 + srand(32'(r < 4 ? 4 :
                     (r > 32'h3FFFFFFF ? 32'h3FFFFFFF : r)));
                send_circle(to_coord(px), to_coord(py), $urandom_range(15) == 0);
            end
        end
        wait_idle();
    endtask

    initial begin
        int total;
        sb = new();
        calm = 0; stall_cycles = 0; timed_out = 0; next_id = 0;
        i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        i_s_tvalid = 0; i_s_tdata = 0; i_s_tlast = 0; i_m_tready = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: reset segment (0,0)-(1,0), radius 1.0
        send_circle(32'h8000, 32'h0, 0);           // centre on segment
        send_circle(32'hFFFF8000, 32'h4CCC, 0);    // nearest the start end
        send_circle(32'h18000, 32'hFFFFCCCD, 0);   // nearest the far end
        send_circle(32'h8000, 32'h8000, 0);        // interior
        send_circle(32'h50000, 32'h50000, 0);      // miss
        send_circle(32'h80000000, 32'h80000000, 0);
        send_circle(32'h7FFFFFFF, 32'h7FFFFFFF, 1);
        next_id = 16'hFFFF;
        send_circle(32'h0, 32'h0, 0);              // on the start end
        wait_idle();
        // Limit reached, then lowered below the count
        reg_write(REG_LIMIT, 2);
        reg_write(REG_BOUNCE, 0);
        repeat (4) send_circle(32'h8000, 32'h1000, 0);
        send_circle(32'h8000, 32'h1000, 1);
        repeat (3) send_circle(32'h4000, 32'hFFFFF000, 0);
        wait_idle();
        reg_write(REG_LIMIT, 0);
        send_circle(32'h8000, 32'h0, 1);
        wait_idle();
        // Zero length segment, extreme corners, widest radius
        reg_write(REG_LIMIT, 255);
        reg_write(REG_BOUNCE, 32'h10000);
        set_segment(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_circle(32'h80000000, 32'h7FFFFFFF, 0);
        send_circle(32'h7FFFFFFF, 32'h80000000, 0);
        send_circle(32'h80010000, 32'h7FFF0000, 1);
        wait_idle();
        set_segment(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0);
        send_circle(32'h0, 32'h0, 1);
        wait_idle();

        // Random phases, five of them with no idling on either side
        total = 0;
        while (total < 1800) begin
            calm = (total >= 600 && total < 900);
            random_phase(60);
            total += 60;
        end
        calm = 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_segment_circle_contact passed");
        else
            $display("tb_segment_circle_contact failed");
        $finish;
    end

endmodule
